FILE: src/odiq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package odiq_pkg;

    // number of qualified input lines
    localparam int NUM_CH = 3;
    localparam int CH_W = 2;
    localparam int COUNTER_WIDTH_DEF = 16;

    // configuration port
    localparam int CFG_W = 16;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE_TICKS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_MODE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PROTOCOL_EDGE = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THIRD_ENABLE = 2'd3;

    localparam logic [CFG_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [NUM_CH-1:0] EDGE_MASK_RESET = 3'b111;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_TICK  = 2'd1,
        OP_ARM   = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_LEVEL   = 2'd0,
        KIND_TRIGGER = 2'd1,
        KIND_READ    = 2'd2
    } kind_t;

    // per-lane control for one accepted word
    typedef struct packed {
        logic start;
        logic tick;
        logic arm;
        logic enabled;
        logic mode;
        logic rising;
    } lane_ctrl_t;

    // event found by one lane
    typedef struct packed {
        logic  fire;
        kind_t kind;
        logic  level;
    } lane_evt_t;

    // one queued result word
    typedef struct packed {
        kind_t           kind;
        logic [CH_W-1:0] channel;
        logic            level;
    } slot_t;

endpackage

`default_nettype wire

FILE: src/opto_input_debounce_qualifier.sv
`timescale 1ns / 1ps
`default_nettype none

// channel   direction  signals                          contents
// s_        in         s_tvalid s_tready s_tdata s_tuser  operation, channel, line levels
// m_        out        m_tvalid m_tready m_tdata m_tuser  kind, channel, level, last
// cfg_      in         cfg_we cfg_index cfg_data          register writes, no read-back
//
// a word is taken on a handshake; its results (zero to three) leave one per cycle while m_tready is high
// from a three-entry result queue, so a tick releasing three events holds the
// input until they have gone; the next word is taken in the cycle the last result goes
// all lane state and the queue count clear on rst_n low; ticks are ignored until start
// a stalled m_ side holds the queue head and stops s_ while any result is waiting

module opto_input_debounce_qualifier #(
    parameter int COUNTER_WIDTH = odiq_pkg::COUNTER_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [7:0]                          s_tdata,   // channel[1:0], line_levels[4:2]
    input  wire  [1:0]                          s_tuser,   // operation[1:0]
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [7:0]                          m_tdata,   // event_channel[1:0], level[2]
    output logic [1:0]                          m_tuser,   // kind[1:0]
    output logic                                m_tlast,
    input  wire                                 cfg_we,
    input  wire  [odiq_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  wire  [odiq_pkg::CFG_W-1:0]          cfg_data
);

    localparam int N = odiq_pkg::NUM_CH;

    logic [odiq_pkg::CFG_W-1:0] debounce_reg;
    logic [N-1:0]               mode_reg;
    logic [N-1:0]               edge_reg;
    logic                       third_en_reg;
    logic                       started_reg;

    odiq_pkg::op_t                   op;
    logic [odiq_pkg::CH_W-1:0]       channel;
    logic [N-1:0]                    lines;
    logic                            accept;
    logic [N-1:0]                    enabled;
    logic [N-1:0]                    confirmed;
    odiq_pkg::lane_evt_t [N-1:0]     evts;
    odiq_pkg::lane_ctrl_t [N-1:0]    ctrl;
    logic                            read_level;
    odiq_pkg::slot_t                 head;

    assign op      = odiq_pkg::op_t'(s_tuser);
    assign channel = s_tdata[1:0];
    assign lines   = s_tdata[4:2];
    assign accept  = s_tvalid && s_tready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            debounce_reg <= odiq_pkg::DEBOUNCE_RESET;
            mode_reg     <= '0;
            edge_reg     <= odiq_pkg::EDGE_MASK_RESET;
            third_en_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                odiq_pkg::CFG_DEBOUNCE_TICKS: debounce_reg <= cfg_data;
                odiq_pkg::CFG_PROTOCOL_MODE:  mode_reg     <= cfg_data[N-1:0];
                odiq_pkg::CFG_PROTOCOL_EDGE:  edge_reg     <= cfg_data[N-1:0];
                odiq_pkg::CFG_THIRD_ENABLE:   third_en_reg <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    // started flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            started_reg <= 1'b0;
        end
        else if (accept && (op == odiq_pkg::OP_START))
        begin
            started_reg <= 1'b1;
        end
    end

    // lanes, one per line
    for (genvar c = 0; c < N; c++)
    begin : g_lane
        assign enabled[c] = (c != 2) || third_en_reg;
        assign ctrl[c] = '{
            start:   accept && (op == odiq_pkg::OP_START),
            tick:    accept && (op == odiq_pkg::OP_TICK) && started_reg,
            arm:     accept && (op == odiq_pkg::OP_ARM) && (channel == odiq_pkg::CH_W'(c)),
            enabled: enabled[c],
            mode:    mode_reg[c],
            rising:  edge_reg[c]
        };

        odiq_lane #(
            .COUNTER_WIDTH (COUNTER_WIDTH)
        ) u_lane (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl[c]),
            .cur       (lines[c]),
            .debounce  (debounce_reg),
            .evt       (evts[c]),
            .confirmed (confirmed[c])
        );
    end

    // read response level
    always_comb
    begin
        read_level = 1'b0;
        for (int c = 0; c < N; c++)
        begin
            if ((channel == odiq_pkg::CH_W'(c)) && enabled[c] && !mode_reg[c])
            begin
                read_level = confirmed[c];
            end
        end
    end

    odiq_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (accept),
        .read_op      (op == odiq_pkg::OP_READ),
        .read_channel (channel),
        .read_level   (read_level),
        .evts         (evts),
        .ready        (s_tready),
        .head_valid   (m_tvalid),
        .head_taken   (m_tready),
        .head         (head),
        .head_last    (m_tlast)
    );

    assign m_tuser = head.kind;
    assign m_tdata = {5'b0, head.level, head.channel};

endmodule

`default_nettype wire

FILE: src/odiq_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module odiq_lane #(
    parameter int COUNTER_WIDTH = odiq_pkg::COUNTER_WIDTH_DEF
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  odiq_pkg::lane_ctrl_t           ctrl,
    input  wire                            cur,
    input  wire  [odiq_pkg::CFG_W-1:0]     debounce,
    output odiq_pkg::lane_evt_t            evt,
    output logic                           confirmed
);

    localparam int CMP_W = (COUNTER_WIDTH > odiq_pkg::CFG_W) ? COUNTER_WIDTH : odiq_pkg::CFG_W;

    logic                     prev_reg, prev_next;
    logic                     confirmed_reg, confirmed_next;
    logic                     pending_reg, pending_next;
    logic                     armed_reg, armed_next;
    logic [COUNTER_WIDTH-1:0] count_reg, count_next;
    logic                     edge_hit;
    logic                     changed;

    assign changed   = cur != prev_reg;
    assign edge_hit  = ctrl.rising ? (!prev_reg && cur) : (prev_reg && !cur);
    assign confirmed = confirmed_reg;

    // next state and event for this line
    always_comb
    begin
        prev_next      = prev_reg;
        confirmed_next = confirmed_reg;
        pending_next   = pending_reg;
        armed_next     = armed_reg;
        count_next     = count_reg;
        evt            = '{fire: 1'b0, kind: odiq_pkg::KIND_LEVEL, level: cur};
        if (ctrl.start)
        begin
            prev_next      = cur;
            confirmed_next = cur;
            pending_next   = 1'b0;
            count_next     = '0;
            armed_next     = ctrl.enabled && ctrl.mode;
        end
        else if (ctrl.tick)
        begin
            prev_next = cur;
            if (ctrl.enabled && ctrl.mode)
            begin
                // protocol trigger on the configured edge
                if (armed_reg && edge_hit)
                begin
                    armed_next = 1'b0;
                    evt.fire   = 1'b1;
                    evt.kind   = odiq_pkg::KIND_TRIGGER;
                end
            end
            else if (ctrl.enabled)
            begin
                // quiet counter restarts on a change and saturates
                if (changed)
                begin
                    count_next   = '0;
                    pending_next = 1'b1;
                end
                else if (count_reg != {COUNTER_WIDTH{1'b1}})
                begin
                    count_next = count_reg + 1'b1;
                end
                if (pending_next && (CMP_W'(count_next) >= CMP_W'(debounce)))
                begin
                    pending_next = 1'b0;
                    if (cur != confirmed_reg)
                    begin
                        confirmed_next = cur;
                        evt.fire       = 1'b1;
                    end
                end
            end
        end
        else if (ctrl.arm && ctrl.enabled && ctrl.mode)
        begin
            armed_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 1'b0;
            confirmed_reg <= 1'b0;
            pending_reg   <= 1'b0;
            armed_reg     <= 1'b0;
            count_reg     <= '0;
        end
        else
        begin
            prev_reg      <= prev_next;
            confirmed_reg <= confirmed_next;
            pending_reg   <= pending_next;
            armed_reg     <= armed_next;
            count_reg     <= count_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/odiq_merge.sv
`timescale 1ns / 1ps
`default_nettype none

module odiq_merge (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        load,
    input  wire                                        read_op,
    input  wire  [odiq_pkg::CH_W-1:0]                  read_channel,
    input  wire                                        read_level,
    input  odiq_pkg::lane_evt_t [odiq_pkg::NUM_CH-1:0] evts,
    output logic                                       ready,
    output logic                                       head_valid,
    input  wire                                        head_taken,
    output odiq_pkg::slot_t                            head,
    output logic                                       head_last
);

    localparam int CNT_W = 2;

    odiq_pkg::slot_t [odiq_pkg::NUM_CH-1:0] slot_reg, slot_next;
    odiq_pkg::slot_t [odiq_pkg::NUM_CH-1:0] fresh;
    logic [CNT_W-1:0]                       cnt_reg, cnt_next;
    logic [CNT_W-1:0]                       fresh_cnt;
    logic                                   pop;

    assign head_valid = cnt_reg != '0;
    assign head       = slot_reg[0];
    assign head_last  = cnt_reg == CNT_W'(1);
    assign pop        = head_valid && head_taken;
    // room for a new word once the queue drains this cycle
    assign ready      = (cnt_reg == '0) || ((cnt_reg == CNT_W'(1)) && head_taken);

    // pack lane events in ascending channel order, or the single read result
    always_comb
    begin
        fresh     = '0;
        fresh_cnt = '0;
        if (read_op)
        begin
            fresh[0]  = '{kind: odiq_pkg::KIND_READ, channel: read_channel, level: read_level};
            fresh_cnt = CNT_W'(1);
        end
        else
        begin
            for (int c = 0; c < odiq_pkg::NUM_CH; c++)
            begin
                if (evts[c].fire)
                begin
                    fresh[fresh_cnt] = '{kind: evts[c].kind,
                                         channel: odiq_pkg::CH_W'(c),
                                         level: evts[c].level};
                    fresh_cnt = fresh_cnt + 1'b1;
                end
            end
        end
    end

    // result queue: load on accept, shift on take
    always_comb
    begin
        slot_next = slot_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            slot_next = fresh;
            cnt_next  = fresh_cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < odiq_pkg::NUM_CH - 1; i++)
            begin
                slot_next[i] = slot_reg[i+1];
            end
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg <= slot_next;
    end

endmodule

`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 150;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int RANDOM_PHASES  = 6;
    localparam int PHASE_WORDS    = 22;

    // one predicted result word
    typedef struct packed {
        odiq_pkg::kind_t kind;
        logic [1:0]      chan;
        logic            level;
        logic            last;
    } qual_event_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [7:0]        s_tdata = '0;    // channel[1:0], line_levels[4:2]
    logic [1:0]        s_tuser = '0;    // operation[1:0]
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [7:0]        m_tdata;         // event_channel[1:0], level[2]
    logic [1:0]        m_tuser;         // kind[1:0]
    logic              m_tlast;
    logic              cfg_we = 1'b0;
    logic [odiq_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [odiq_pkg::CFG_W-1:0]     cfg_data = '0;

    // predictor copy of the registers
    logic [15:0]       cfg_debounce = odiq_pkg::DEBOUNCE_RESET;
    logic [2:0]        cfg_mode = 3'b000;
    logic [2:0]        cfg_edge = odiq_pkg::EDGE_MASK_RESET;
    logic              cfg_third = 1'b0;

    // predictor copy of the lane state
    logic [2:0]        lane_prev = '0;
    logic [2:0]        lane_confirmed = '0;
    logic [2:0]        lane_pending = '0;
    logic [15:0]       quiet_count [odiq_pkg::NUM_CH];
    logic [2:0]        lane_armed = '0;
    logic              lane_started = 1'b0;

    qual_event_t       expected_events [$];

    int                idle_pct = 22;
    int                hold_seq = 0;
    int                hold_seen = 0;
    int                hold_left = 0;
    int                stall_cycles = 0;
    int                errors = 0;
    int                words_sent = 0;
    int                events_checked = 0;

    opto_input_debounce_qualifier dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #2 clk = ~clk;

    // channel two takes part only when enabled
    function automatic logic lane_on(int c);
        return (c < odiq_pkg::NUM_CH) && !(c == 2 && !cfg_third);
    endfunction

    // works out the result words of one accepted input word
    function automatic void predict_qualifier(odiq_pkg::op_t op, logic [1:0] ch,
                                              logic [2:0] lines);
        qual_event_t found [$];
        qual_event_t ev;
        logic        cur;
        logic        prv;
        logic        hit;
        int          c;
        case (op)
            odiq_pkg::OP_START:
            begin
                lane_prev = lines;
                lane_confirmed = lines;
                lane_pending = '0;
                for (c = 0; c < odiq_pkg::NUM_CH; c++)
                    quiet_count[c] = '0;
                lane_armed = '0;
                for (c = 0; c < odiq_pkg::NUM_CH; c++)
                    if (lane_on(c) && cfg_mode[c])
                        lane_armed[c] = 1'b1;
                lane_started = 1'b1;
            end
            odiq_pkg::OP_TICK:
            begin
                if (lane_started)
                begin
                    for (c = 0; c < odiq_pkg::NUM_CH; c++)
                    begin
                        if (lane_on(c))
                        begin
                            cur = lines[c];
                            prv = lane_prev[c];
                            if (cfg_mode[c])
                            begin
                                // protocol lane fires once on its edge, then disarms
                                hit = cfg_edge[c] ? (!prv && cur) : (prv && !cur);
                                if (lane_armed[c] && hit)
                                begin
                                    lane_armed[c] = 1'b0;
                                    ev.kind = odiq_pkg::KIND_TRIGGER;
                                    ev.chan = 2'(c);
                                    ev.level = cur;
                                    ev.last = 1'b0;
                                    found.push_back(ev);
                                end
                            end
                            else
                            begin
                                // level lane: restart on change, saturate when quiet
                                if (cur != prv)
                                begin
                                    quiet_count[c] = '0;
                                    lane_pending[c] = 1'b1;
                                end
                                else if (quiet_count[c] != 16'hFFFF)
                                    quiet_count[c] = quiet_count[c] + 16'd1;
                                if (lane_pending[c] && quiet_count[c] >= cfg_debounce)
                                begin
                                    lane_pending[c] = 1'b0;
                                    if (cur != lane_confirmed[c])
                                    begin
                                        lane_confirmed[c] = cur;
                                        ev.kind = odiq_pkg::KIND_LEVEL;
                                        ev.chan = 2'(c);
                                        ev.level = cur;
                                        ev.last = 1'b0;
                                        found.push_back(ev);
                                    end
                                end
                            end
                        end
                    end
                    lane_prev = lines;
                    for (c = 0; c < found.size(); c++)
                    begin
                        ev = found[c];
                        ev.last = (c == found.size() - 1);
                        expected_events.push_back(ev);
                    end
                end
            end
            odiq_pkg::OP_ARM:
            begin
                if (lane_on(int'(ch)) && cfg_mode[ch])
                    lane_armed[ch] = 1'b1;
            end
            default:
            begin
                ev.kind = odiq_pkg::KIND_READ;
                ev.chan = ch;
                ev.level = (lane_on(int'(ch)) && !cfg_mode[ch]) ? lane_confirmed[ch] : 1'b0;
                ev.last = 1'b1;
                expected_events.push_back(ev);
            end
        endcase
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    // sends one word; valid stays high until the next idle gap
    task automatic send_word(odiq_pkg::op_t op, logic [1:0] ch, logic [2:0] lines);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= op;
        s_tdata <= {3'b000, lines, ch};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_qualifier(op, ch, lines);
        words_sent++;
    endtask

    // drain all results and let the block go quiet
    task automatic settle;
        s_tvalid <= 1'b0;
        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // writes all four registers on back-to-back cycles
    task automatic set_config(logic [15:0] db, logic [2:0] mode, logic [2:0] edg, logic third);
        settle();
        cfg_we <= 1'b1;
        cfg_index <= odiq_pkg::CFG_DEBOUNCE_TICKS;
        cfg_data <= db;
        @(posedge clk);
        cfg_index <= odiq_pkg::CFG_PROTOCOL_MODE;
        cfg_data <= odiq_pkg::CFG_W'(mode);
        @(posedge clk);
        cfg_index <= odiq_pkg::CFG_PROTOCOL_EDGE;
        cfg_data <= odiq_pkg::CFG_W'(edg);
        @(posedge clk);
        cfg_index <= odiq_pkg::CFG_THIRD_ENABLE;
        cfg_data <= odiq_pkg::CFG_W'(third);
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_debounce = db;
        cfg_mode = mode;
        cfg_edge = edg;
        cfg_third = third;
    endtask

    // reset defaults: ticks ignored, reads of invalid and disabled lanes
    task automatic test_before_start;
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b111);
        send_word(odiq_pkg::OP_ARM, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_READ, 2'd3, 3'b000);
        send_word(odiq_pkg::OP_START, 2'd0, 3'b101);
        send_word(odiq_pkg::OP_READ, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_READ, 2'd2, 3'b000);
    endtask

    // zero debounce confirms on the edge tick, three events per tick
    task automatic test_level_fast;
        set_config(16'd0, 3'b000, 3'b111, 1'b1);
        send_word(odiq_pkg::OP_START, 2'd1, 3'b000);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b111);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_READ, 2'd2, 3'b000);
    endtask

    // debounce of two, plus a glitch that settles back to the confirmed level
    task automatic test_level_glitch;
        set_config(16'd2, 3'b000, 3'b111, 1'b1);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b011);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_READ, 2'd1, 3'b000);
    endtask

    // protocol edges, disarm after firing, rearm, invalid arm
    task automatic test_protocol_edges;
        set_config(16'd5, 3'b111, 3'b101, 1'b1);
        send_word(odiq_pkg::OP_START, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b111);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_ARM, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_ARM, 2'd3, 3'b000);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b001);
        send_word(odiq_pkg::OP_READ, 2'd1, 3'b000);
    endtask

    // mode switch after start, disabled third lane, debounce at its maximum
    task automatic test_disabled_channel;
        set_config(16'hFFFF, 3'b110, 3'b000, 1'b0);
        send_word(odiq_pkg::OP_READ, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_ARM, 2'd2, 3'b000);
        send_word(odiq_pkg::OP_START, 2'd0, 3'b111);
        send_word(odiq_pkg::OP_TICK, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_READ, 2'd0, 3'b000);
        send_word(odiq_pkg::OP_READ, 2'd2, 3'b000);
    endtask

    // receiver holds off while the sender keeps pushing three-event ticks
    task automatic test_output_stall;
        int k;
        set_config(16'd0, 3'b000, 3'b111, 1'b1);
        idle_pct = 0;
        send_word(odiq_pkg::OP_START, 2'd0, 3'b000);
        hold_seq++;
        for (k = 0; k < 10; k++)
            send_word(odiq_pkg::OP_TICK, 2'd0, (k % 2 == 0) ? 3'b111 : 3'b000);
        idle_pct = 22;
    endtask

    // random phases, each under its own register setting
    task automatic test_random_traffic;
        logic [2:0] walk;
        int         p;
        int         k;
        int         r;
        for (p = 0; p < RANDOM_PHASES; p++)
        begin
            case (p)
                0: set_config(16'd0, 3'b000, 3'b111, 1'b1);
                1: set_config(16'hFFFF, 3'b010, 3'b000, 1'b1);
                2: set_config(16'($urandom_range(0, 3)), 3'b111, 3'($urandom_range(0, 7)), 1'b1);
                default: set_config(16'($urandom_range(0, 4)), 3'($urandom_range(0, 7)),
                                    3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
            endcase
            // one phase runs with no idling on either side
            idle_pct = (p == 2) ? 0 : 22;
            walk = 3'($urandom_range(0, 7));
            send_word(odiq_pkg::OP_START, 2'($urandom_range(0, 3)), walk);
            for (k = 0; k < PHASE_WORDS; k++)
            begin
                r = $urandom_range(99);
                if (r < 6)
                begin
                    walk = 3'($urandom_range(0, 7));
                    send_word(odiq_pkg::OP_START, 2'($urandom_range(0, 3)), walk);
                end
                else if (r < 66)
                begin
                    // lines mostly hold so that debouncing can complete
                    if ($urandom_range(99) < 35)
                        walk = walk ^ 3'($urandom_range(1, 7));
                    send_word(odiq_pkg::OP_TICK, 2'($urandom_range(0, 3)), walk);
                end
                else if (r < 80)
                    send_word(odiq_pkg::OP_ARM, 2'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)));
                else
                    send_word(odiq_pkg::OP_READ, 2'($urandom_range(0, 3)),
                              3'($urandom_range(0, 7)));
            end
        end
        idle_pct = 22;
    endtask

    // result receiver with random stalls and one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_seen != hold_seq)
        begin
            hold_seen <= hold_seq;
            hold_left <= HOLD_CYCLES;
            m_tready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= idle_pct);
    end

    // compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        qual_event_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected result word, expected none, got kind %0d chan %0d",
                         $time, m_tuser, m_tdata[1:0]);
                errors++;
            end
            else
            begin
                want = expected_events.pop_front();
                check_field("kind", want.kind, m_tuser);
                check_field("event_channel", want.chan, m_tdata[1:0]);
                check_field("level", want.level, m_tdata[2]);
                check_field("last", want.last, m_tlast);
                events_checked++;
            end
        end
    end

    // watchdog on cycles with no handshake and no register write
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        for (int c = 0; c < odiq_pkg::NUM_CH; c++)
            quiet_count[c] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_before_start();
        test_level_fast();
        test_level_glitch();
        test_protocol_edges();
        test_disabled_channel();
        test_output_stall();
        test_random_traffic();
        settle();
        if (expected_events.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time,
                     expected_events.size());
            errors++;
        end
        $display("run: %0d input words sent, %0d result words checked, %0d errors",
                 words_sent, events_checked, errors);
        $display("run: level and protocol lanes, reads, disabled lane, output stall, random");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: files.f
src/odiq_pkg.sv
src/odiq_lane.sv
src/odiq_merge.sv
src/opto_input_debounce_qualifier.sv
sim/testbench.sv
